### rtl/core/mau_pkg.sv
// ---------------------------------------------------------------------------
// mau_pkg: shared types and constants for the modular arithmetic unit
// Command codes, modulus width, reset modulus and the modular multiply request and response structs.
// ---------------------------------------------------------------------------
package mau_pkg;

	localparam int unsigned MOD_W = 31;
	localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

	typedef enum logic [2:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_DIV = 3'd3,
		CMD_POW = 3'd4,
		CMD_INV = 3'd5
	} cmd_t;

	typedef struct packed {
		logic             go;
		logic [MOD_W-1:0] x;
		logic [MOD_W-1:0] y;
	} mul_req_t;

	typedef struct packed {
		logic             done;
		logic [MOD_W-1:0] p;
	} mul_rsp_t;

endpackage

### rtl/core/mau_reduce.sv
// ---------------------------------------------------------------------------
// mau_reduce: bit-serial reduction of an operand modulo m
// Restoring shift-subtract, one operand bit per cycle, MSB first.
// ---------------------------------------------------------------------------
module mau_reduce #(
	parameter int unsigned OPERAND_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           go,
	input  logic [OPERAND_BITS-1:0]        value,
	input  logic [mau_pkg::MOD_W-1:0]      m,
	output logic                           done,
	output logic [mau_pkg::MOD_W-1:0]      rem
);
	localparam int unsigned CW = $clog2(OPERAND_BITS + 1);

	logic [OPERAND_BITS-1:0]   val_q;
	logic [mau_pkg::MOD_W:0]   rem_q;
	logic [CW-1:0]             cnt_q;
	logic                      busy_q;
	logic [mau_pkg::MOD_W+1:0] sh;
	logic [mau_pkg::MOD_W+1:0] df;

	assign sh = {rem_q, val_q[OPERAND_BITS-1]};
	assign df = sh - {2'b00, m};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(OPERAND_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			val_q <= value;
			rem_q <= '0;
		end else if (busy_q) begin
			val_q <= val_q << 1;
			// keep the remainder below m each step
			rem_q <= df[mau_pkg::MOD_W+1] ? sh[mau_pkg::MOD_W:0] : df[mau_pkg::MOD_W:0];
		end
	end

	assign rem = rem_q[mau_pkg::MOD_W-1:0];
endmodule

### rtl/core/mau_mulmod.sv
// ---------------------------------------------------------------------------
// mau_mulmod: modular multiplier
// One 31x31 product, then bit-serial reduction of the 62-bit product.
// ---------------------------------------------------------------------------
module mau_mulmod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mau_pkg::mul_req_t         req,
	input  logic [mau_pkg::MOD_W-1:0] m,
	output mau_pkg::mul_rsp_t         rsp
);
	localparam int unsigned PW = 2 * mau_pkg::MOD_W;
	localparam int unsigned CW = $clog2(PW + 2);

	logic [PW-1:0]             prod_q;
	logic [mau_pkg::MOD_W:0]   rem_q;
	logic [CW-1:0]             cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [mau_pkg::MOD_W+1:0] sh;
	logic [mau_pkg::MOD_W+1:0] df;

	assign sh = {rem_q, prod_q[PW-1]};
	assign df = sh - {2'b00, m};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(PW + 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// first busy cycle only latches the product; the rest reduce it
	always_ff @(posedge clk) begin
		if (req.go) begin
			prod_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == CW'(PW + 1)) begin
				prod_q <= PW'(req.x) * PW'(req.y);
			end else begin
				prod_q <= prod_q << 1;
				rem_q  <= df[mau_pkg::MOD_W+1] ? sh[mau_pkg::MOD_W:0]
				                               : df[mau_pkg::MOD_W:0];
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = rem_q[mau_pkg::MOD_W-1:0];
endmodule

### rtl/core/modular_arithmetic_unit_top.sv
// Time to result_valid: add, subtract and unused commands take the two operand reductions;
// multiply adds one modular product; power, inverse and divide run square-and-multiply
// over the exponent, and divide ends with one more product.
// Throughput: one command at a time; busy drops with the result_valid pulse, no stall.
// Reset clears control state and loads the modulus with 1000000007.
// ---------------------------------------------------------------------------
// modular_arithmetic_unit_top: modular add/sub/mul/div/pow/inv
// Sequencer around a shared operand reducer and a shared modular multiplier.
// ---------------------------------------------------------------------------
module modular_arithmetic_unit_top #(
	parameter int unsigned OPERAND_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [2:0]                 command,
	input  logic [OPERAND_BITS-1:0]    operand_a,
	input  logic [OPERAND_BITS-1:0]    operand_b,
	output logic                       result_valid,
	output logic [mau_pkg::MOD_W-1:0]  result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [mau_pkg::MOD_W-1:0]  cfg_data
);
	localparam int unsigned EW = (OPERAND_BITS > mau_pkg::MOD_W) ? OPERAND_BITS : mau_pkg::MOD_W;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_REDA  = 8'b0000_0010,
		S_REDB  = 8'b0000_0100,
		S_ARITH = 8'b0000_1000,
		S_PMUL  = 8'b0001_0000,
		S_PSQR  = 8'b0010_0000,
		S_FMUL  = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t                    state_q;
	logic [mau_pkg::MOD_W-1:0] mod_q, ar_q, br_q, acc_q, base_q, res_q;
	logic [EW-1:0]             exp_q;
	logic [2:0]                cmd_q;
	logic [OPERAND_BITS-1:0]   a_q, b_q;
	logic                      div_q;
	logic                      red_go, red_done;
	logic [OPERAND_BITS-1:0]   red_sel;
	logic [mau_pkg::MOD_W-1:0] red_rem;
	mau_pkg::mul_req_t         mreq;
	mau_pkg::mul_rsp_t         mrsp;
	logic [mau_pkg::MOD_W:0]   sum;
	logic [mau_pkg::MOD_W:0]   sum_m;
	logic [mau_pkg::MOD_W:0]   dif;
	logic                      mod_ok;
	logic                      red_go_q, mul_go_q;
	logic                      pm_wait_q;

	assign mod_ok  = (mod_q >= mau_pkg::MOD_W'(2));
	assign busy    = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mod_q <= mau_pkg::MODULUS_RESET;
		else if (cfg_valid && cfg_ready)
			mod_q <= cfg_data;
	end

	assign red_go  = red_go_q;
	assign red_sel = (state_q == S_REDA) ? a_q : b_q;

	mau_reduce #(.OPERAND_BITS(OPERAND_BITS)) u_red (
		.clk(clk), .arst_n(arst_n), .go(red_go), .value(red_sel),
		.m(mod_q), .done(red_done), .rem(red_rem)
	);

	assign mreq.go = mul_go_q;
	assign mreq.x  = (state_q == S_PSQR) ? base_q : (state_q == S_ARITH) ? ar_q : acc_q;
	assign mreq.y  = (state_q == S_FMUL) ? ar_q : (state_q == S_ARITH) ? br_q : base_q;

	mau_mulmod u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .m(mod_q), .rsp(mrsp));

	// second operand remainder is taken straight from the reducer
	assign sum   = {1'b0, ar_q} + {1'b0, red_rem};
	assign sum_m = sum - {1'b0, mod_q};
	assign dif   = {1'b0, ar_q} - {1'b0, red_rem};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			result_valid <= 1'b0;
			red_go_q     <= 1'b0;
			mul_go_q     <= 1'b0;
			pm_wait_q    <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			red_go_q     <= 1'b0;
			mul_go_q     <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q  <= S_REDA;
						red_go_q <= 1'b1;
					end
				end
				S_REDA: begin
					if (red_done) begin
						state_q  <= S_REDB;
						red_go_q <= 1'b1;
					end
				end
				S_REDB: begin
					if (red_done) begin
						if (!mod_ok) begin
							state_q <= S_DONE;
						end else begin
							unique case (cmd_q) inside
								mau_pkg::CMD_MUL: begin
									state_q  <= S_ARITH;
									mul_go_q <= 1'b1;
								end
								mau_pkg::CMD_POW, mau_pkg::CMD_DIV, mau_pkg::CMD_INV: begin
									state_q <= S_PMUL;
								end
								default: state_q <= S_DONE;
							endcase
						end
					end
				end
				S_ARITH: begin
					if (mrsp.done)
						state_q <= S_DONE;
				end
				// square-and-multiply, exponent LSB first
				S_PMUL: begin
					if (pm_wait_q) begin
						if (mrsp.done) begin
							state_q   <= S_PSQR;
							mul_go_q  <= 1'b1;
							pm_wait_q <= 1'b0;
						end
					end else if (exp_q == '0) begin
						if (div_q) begin
							state_q  <= S_FMUL;
							mul_go_q <= 1'b1;
						end else
							state_q <= S_DONE;
					end else if (exp_q[0]) begin
						// hold here until the accumulator product returns
						mul_go_q  <= 1'b1;
						pm_wait_q <= 1'b1;
					end else begin
						state_q  <= S_PSQR;
						mul_go_q <= 1'b1;
					end
				end
				S_PSQR: begin
					if (mrsp.done)
						state_q <= S_PMUL;
				end
				S_FMUL: begin
					if (mrsp.done)
						state_q <= S_DONE;
				end
				S_DONE: begin
					state_q      <= S_IDLE;
					result_valid <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_q <= command;
					a_q   <= operand_a;
					b_q   <= operand_b;
					res_q <= '0;
				end
			end
			S_REDA: if (red_done) ar_q <= red_rem;
			S_REDB: begin
				if (red_done) begin
					br_q   <= red_rem;
					div_q  <= (cmd_q == mau_pkg::CMD_DIV);
					if (cmd_q == mau_pkg::CMD_POW) begin
						base_q <= ar_q;
						exp_q  <= EW'(b_q);
						acc_q  <= mau_pkg::MOD_W'(1);
					end else if (cmd_q == mau_pkg::CMD_INV) begin
						base_q <= ar_q;
						exp_q  <= (ar_q == '0) ? '0 : EW'(mod_q - mau_pkg::MOD_W'(2));
						acc_q  <= (ar_q == '0) ? '0 : mau_pkg::MOD_W'(1);
					end else begin
						base_q <= red_rem;
						exp_q  <= (red_rem == '0) ? '0 : EW'(mod_q - mau_pkg::MOD_W'(2));
						acc_q  <= (red_rem == '0) ? '0 : mau_pkg::MOD_W'(1);
					end
					if (mod_ok) begin
						if (cmd_q == mau_pkg::CMD_ADD)
							res_q <= sum_m[mau_pkg::MOD_W] ? sum[mau_pkg::MOD_W-1:0]
							                               : sum_m[mau_pkg::MOD_W-1:0];
						else if (cmd_q == mau_pkg::CMD_SUB)
							res_q <= dif[mau_pkg::MOD_W] ? (dif[mau_pkg::MOD_W-1:0] + mod_q)
							                             : dif[mau_pkg::MOD_W-1:0];
					end
				end
			end
			S_PMUL: begin
				if (mrsp.done)
					acc_q <= mrsp.p;
				else if (!pm_wait_q && exp_q == '0)
					res_q <= acc_q;
			end
			S_PSQR: begin
				if (mrsp.done) begin
					base_q <= mrsp.p;
					exp_q  <= exp_q >> 1;
				end
			end
			S_ARITH, S_FMUL: if (mrsp.done) res_q <= mrsp.p;
			default: ;
		endcase
	end

	assign result = res_q;
endmodule

### rtl/core/mau_checker.sv
// ---------------------------------------------------------------------------
// mau_checker: port-level checks for the modular arithmetic unit
// Watches handshake and result timing at the top-level ports.
// ---------------------------------------------------------------------------
module mau_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      result_valid,
	input logic                      cfg_ready
);
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted beat did not raise busy");
	a_strobe_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("result strobe longer than one beat");
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy) else $error("result shown while busy");
	a_strobe_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(busy)) else $error("result without command");
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> !busy) else $error("config ready while busy");
endmodule

bind modular_arithmetic_unit_top mau_checker u_mau_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.result_valid(result_valid), .cfg_ready(cfg_ready)
);

### tb/sv/modular_arithmetic_unit_top_tb.sv
// ---------------------------------------------------------------------------
// modular_arithmetic_unit_top_tb: self-checking bench for the modular unit
// Queue-fed command driver, result monitor against a modular arithmetic
// predictor, with modulus changes between phases and random start gaps.
// ---------------------------------------------------------------------------
module modular_arithmetic_unit_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {BEAT_CMD, BEAT_MOD, BEAT_DRAIN} beat_kind_t;

	typedef struct {
		beat_kind_t                kind;
		logic [2:0]                op;
		logic [31:0]               a;
		logic [31:0]               b;
		logic [mau_pkg::MOD_W-1:0] m;
	} beat_t;

	localparam logic [2:0] CMD_UNUSED6 = 3'd6;
	localparam logic [2:0] CMD_UNUSED7 = 3'd7;
	localparam int TAIL_CYCLES = 2400;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic [2:0]                command;
	logic [31:0]               operand_a;
	logic [31:0]               operand_b;
	logic                      result_valid;
	logic [mau_pkg::MOD_W-1:0] result;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [mau_pkg::MOD_W-1:0] cfg_data;

	beat_t                     pending_beats[$];
	logic [mau_pkg::MOD_W-1:0] expected_results[$];
	logic [mau_pkg::MOD_W-1:0] cur_modulus;
	int                        gap_cnt;
	int                        mismatch_cnt;

	modular_arithmetic_unit_top #(.OPERAND_BITS(32)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .operand_a(operand_a), .operand_b(operand_b),
		.result_valid(result_valid), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned pow_mod(longint unsigned base,
			longint unsigned ex, longint unsigned m);
		longint unsigned acc;
		acc = 1 % m;
		base = base % m;
		while (ex != 0) begin
			if (ex[0]) acc = (acc * base) % m;
			base = (base * base) % m;
			ex = ex >> 1;
		end
		return acc;
	endfunction

	function automatic longint unsigned inv_mod(longint unsigned x, longint unsigned m);
		x = x % m;
		if (x == 0) return 0;
		return pow_mod(x, m - 2, m);
	endfunction

	function automatic logic [mau_pkg::MOD_W-1:0] mod_result(logic [2:0] op,
			logic [31:0] a, logic [31:0] b, logic [mau_pkg::MOD_W-1:0] mod);
		longint unsigned m, ar, br, r;
		m = 64'(mod);
		r = 0;
		if (m >= 2) begin
			ar = a % m;
			br = b % m;
			case (op)
				mau_pkg::CMD_ADD: r = (ar + br) % m;
				mau_pkg::CMD_SUB: r = (ar + m - br) % m;
				mau_pkg::CMD_MUL: r = (ar * br) % m;
				mau_pkg::CMD_DIV: r = (ar * inv_mod(br, m)) % m;
				mau_pkg::CMD_POW: r = pow_mod(ar, 64'(b), m);
				mau_pkg::CMD_INV: r = inv_mod(ar, m);
				default: r = 0;
			endcase
		end
		return r[mau_pkg::MOD_W-1:0];
	endfunction

	function automatic int draw_gap();
		if ($urandom_range(0, 3) == 0) return 0;
		return $urandom_range(0, 5);
	endfunction

	task automatic report_mismatch(string what, logic [mau_pkg::MOD_W-1:0] got,
			logic [mau_pkg::MOD_W-1:0] want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		mismatch_cnt++;
	endtask

	task automatic push_cmd(logic [2:0] op, logic [31:0] a, logic [31:0] b);
		beat_t bt;
		bt.kind = BEAT_CMD;
		bt.op = op;
		bt.a = a;
		bt.b = b;
		bt.m = '0;
		pending_beats.push_back(bt);
	endtask

	task automatic push_mod(logic [mau_pkg::MOD_W-1:0] m);
		beat_t bt;
		bt.kind = BEAT_MOD;
		bt.op = mau_pkg::CMD_ADD;
		bt.a = '0;
		bt.b = '0;
		bt.m = m;
		pending_beats.push_back(bt);
	endtask

	task automatic push_drain();
		beat_t bt;
		bt.kind = BEAT_DRAIN;
		bt.op = mau_pkg::CMD_ADD;
		bt.a = '0;
		bt.b = '0;
		bt.m = '0;
		pending_beats.push_back(bt);
	endtask

	function automatic logic [31:0] draw_operand(logic [mau_pkg::MOD_W-1:0] m);
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 15);
			1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			2: return {1'b0, m} + $urandom_range(0, 2) - 1;
			3: return {1'b0, m} * $urandom_range(0, 2);
			default: return $urandom;
		endcase
	endfunction

	// Keep the slow commands (divide, power, inverse) to about a third.
	task automatic push_random(int n, logic [mau_pkg::MOD_W-1:0] m);
		logic [2:0] op;
		logic [31:0] b;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3: op = mau_pkg::CMD_ADD;
				4, 5, 6, 7: op = mau_pkg::CMD_SUB;
				8, 9, 10, 11: op = mau_pkg::CMD_MUL;
				12, 13: op = mau_pkg::CMD_DIV;
				14, 15: op = mau_pkg::CMD_POW;
				16, 17: op = mau_pkg::CMD_INV;
				18: op = CMD_UNUSED6;
				default: op = ($urandom_range(0, 1) != 0) ? CMD_UNUSED7 : mau_pkg::CMD_POW;
			endcase
			b = draw_operand(m);
			if (op == mau_pkg::CMD_POW && $urandom_range(0, 2) == 0) b = $urandom_range(0, 40);
			push_cmd(op, draw_operand(m), b);
		end
	endtask

	// Driver: one decision per edge, so start and cfg_valid never get two updates.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			command <= mau_pkg::CMD_ADD;
			operand_a <= '0;
			operand_b <= '0;
			cfg_valid <= 1'b0;
			cfg_data <= '0;
			cur_modulus <= mau_pkg::MODULUS_RESET;
			gap_cnt <= 0;
		end else if (cfg_valid) begin
			if (cfg_ready) begin
				cfg_valid <= 1'b0;
				cur_modulus <= cfg_data;
				void'(pending_beats.pop_front());
				gap_cnt <= draw_gap();
			end
		end else if (start) begin
			if (!busy) begin
				expected_results.push_back(mod_result(command, operand_a, operand_b,
					cur_modulus));
				start <= 1'b0;
				void'(pending_beats.pop_front());
				gap_cnt <= draw_gap();
			end
		end else if (gap_cnt > 0) begin
			gap_cnt <= gap_cnt - 1;
		end else if (pending_beats.size() > 0) begin
			case (pending_beats[0].kind)
				BEAT_CMD: begin
					command <= pending_beats[0].op;
					operand_a <= pending_beats[0].a;
					operand_b <= pending_beats[0].b;
					start <= 1'b1;
				end
				BEAT_MOD: begin
					// write only once the unit has gone quiet
					if (expected_results.size() == 0 && !busy && !result_valid) begin
						cfg_data <= pending_beats[0].m;
						cfg_valid <= 1'b1;
					end
				end
				default: begin
					if (expected_results.size() == 0) void'(pending_beats.pop_front());
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", result, '0);
			end else begin
				if (result !== expected_results[0])
					report_mismatch("result", result, expected_results[0]);
				void'(expected_results.pop_front());
			end
		end
	end

	initial begin
		logic [mau_pkg::MOD_W-1:0] m_rand;
		mismatch_cnt = 0;
		arst_n = 1'b0;
		// directed beats at the reset modulus
		push_cmd(mau_pkg::CMD_ADD, 32'h0, 32'h0);
		push_cmd(mau_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_cmd(mau_pkg::CMD_SUB, 32'h0, 32'd1);
		push_cmd(mau_pkg::CMD_SUB, 32'd1000000006, 32'hFFFF_FFFF);
		push_cmd(mau_pkg::CMD_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_cmd(mau_pkg::CMD_MUL, 32'd1000000006, 32'd1000000006);
		push_cmd(mau_pkg::CMD_DIV, 32'd12345, 32'd0);
		push_cmd(mau_pkg::CMD_DIV, 32'd12345, 32'd1000000007);
		push_cmd(mau_pkg::CMD_DIV, 32'hFFFF_FFFF, 32'd3);
		push_cmd(mau_pkg::CMD_POW, 32'd0, 32'd0);
		push_cmd(mau_pkg::CMD_POW, 32'd7, 32'd0);
		push_cmd(mau_pkg::CMD_POW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_cmd(mau_pkg::CMD_POW, 32'd2, 32'd30);
		push_cmd(mau_pkg::CMD_INV, 32'd0, 32'hFFFF_FFFF);
		push_cmd(mau_pkg::CMD_INV, 32'd1000000007, 32'd5);
		push_cmd(mau_pkg::CMD_INV, 32'd2, 32'd0);
		push_cmd(CMD_UNUSED6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_cmd(CMD_UNUSED7, 32'd9, 32'd9);
		push_random(150, mau_pkg::MODULUS_RESET);
		push_drain();
		push_random(30, mau_pkg::MODULUS_RESET);
		push_mod(31'h7FFF_FFFF);
		push_cmd(mau_pkg::CMD_INV, 32'h7FFF_FFFE, 32'd0);
		push_cmd(mau_pkg::CMD_MUL, 32'h7FFF_FFFE, 32'hFFFF_FFFF);
		push_random(150, 31'h7FFF_FFFF);
		push_mod(31'd2);
		push_cmd(mau_pkg::CMD_INV, 32'd1, 32'd0);
		push_random(60, 31'd2);
		push_mod(31'd3);
		push_random(60, 31'd3);
		push_mod(31'd0);
		push_random(15, 31'd0);
		push_mod(31'd1);
		push_random(15, 31'd1);
		push_mod(31'd65537);
		push_random(120, 31'd65537);
		// composite modulus: Fermat path still runs
		push_mod(31'd1000000);
		push_random(40, 31'd1000000);
		m_rand = mau_pkg::MOD_W'($urandom);
		push_mod(m_rand);
		push_random(120, m_rand);
		push_mod(mau_pkg::MODULUS_RESET);
		push_random(60, mau_pkg::MODULUS_RESET);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_beats.size() != 0 || expected_results.size() != 0 || start)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && expected_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#200_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
